>>> src/im2col_pkg.sv
// ----------------------------------------------------------------------------
// im2col_pkg
// shared types, constants and codes of the im2col unfold engine
// ----------------------------------------------------------------------------
`default_nettype none

package im2col_pkg;

  // store geometry and fixed window geometry
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int STRIDE_H    = 1;
  localparam int STRIDE_W    = 1;
  localparam int PAD_H       = 0;
  localparam int PAD_W       = 0;

  // width of orow*stride + krow before the padding offset
  localparam int ROW_CALC_W  = $clog2(255 * STRIDE_H + 15 + 1) + 1;
  localparam int COL_CALC_W  = $clog2(255 * STRIDE_W + 15 + 1) + 1;

  // flat source index partial products
  localparam int P1_W = 14;  // image * channels + chan
  localparam int P2_W = 22;  // p1 * height + row
  localparam int P3_W = 31;  // p2 * width + col

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register highs
  localparam logic [6:0] BATCH_HIGH   = 7'd64;
  localparam logic [8:0] DIM_HIGH     = 9'd256;
  localparam logic [4:0] KERNEL_HIGH  = 5'd16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef enum logic [2:0] {
    REG_BATCH_COUNT   = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_IN_HEIGHT     = 3'd2,
    REG_IN_WIDTH      = 3'd3,
    REG_KERNEL_HEIGHT = 3'd4,
    REG_KERNEL_WIDTH  = 3'd5,
    REG_OUT_HEIGHT    = 3'd6,
    REG_OUT_WIDTH     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_DROP = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_EMIT = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic        op;
    logic [11:0] element_index;
    logic [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] col_value;
    logic        is_padding;
    logic        last_element;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [11:0] index;
    logic [31:0] value;
  } cmd_t;

  // effective register values, already clamped to their legal range
  typedef struct packed {
    logic [6:0] batch_count;
    logic [8:0] channel_count;
    logic [8:0] in_height;
    logic [8:0] in_width;
    logic [4:0] kernel_height;
    logic [4:0] kernel_width;
    logic [8:0] out_height;
    logic [8:0] out_width;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/im2col_front.sv
// ----------------------------------------------------------------------------
// im2col_front
// accepts requests and sorts them into load, emit or dropped load
// ----------------------------------------------------------------------------
`default_nettype none

module im2col_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire im2col_pkg::in_item_t  in_i,
  output logic                       push_o,
  output im2col_pkg::cmd_t           cmd_o,
  input  wire logic                  q_full_i
);
  import im2col_pkg::*;

  logic in_range;

  assign in_range   = 32'(in_i.element_index) < 32'(STORE_DEPTH);
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.index = in_i.element_index;
    cmd_o.value = in_i.element_value;
    if (in_i.op == OP_EMIT) begin
      cmd_o.kind = CMD_EMIT;
    end else if (in_range) begin
      cmd_o.kind = CMD_LOAD;
    end else begin
      cmd_o.kind = CMD_DROP;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (in_i.op == OP_EMIT) |-> cmd_o.kind == CMD_EMIT)
    else $error("emit request misclassified");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full_i |-> !push_o)
    else $error("push while queue full");
  a_load_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (in_i.op == OP_LOAD) |-> cmd_o.kind != CMD_EMIT)
    else $error("load request misclassified");
`endif

endmodule

`default_nettype wire

>>> src/im2col_queue.sv
// ----------------------------------------------------------------------------
// im2col_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module im2col_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire im2col_pkg::cmd_t  cmd_i,
  output logic                   full_o,
  output logic                   valid_o,
  output im2col_pkg::cmd_t       cmd_o,
  input  wire logic              pop_i
);
  import im2col_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of bounds");
`endif

endmodule

`default_nettype wire

>>> src/im2col_back.sv
// ----------------------------------------------------------------------------
// im2col_back
// executes loads into the tensor store and walks the column matrix on emits
// ----------------------------------------------------------------------------
`default_nettype none

module im2col_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire im2col_pkg::cfg_t      cfg_i,
  input  wire logic                  q_valid_i,
  input  wire im2col_pkg::cmd_t      q_cmd_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output im2col_pkg::out_item_t      out_o
);
  import im2col_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_MUL2 = 6'b000100,
    ST_MUL3 = 6'b001000,
    ST_READ = 6'b010000,
    ST_OUT  = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [31:0] mem [STORE_DEPTH];

  // sweep counters
  logic [7:0] chan_q, chan_d;
  logic [3:0] krow_q, krow_d;
  logic [3:0] kcol_q, kcol_d;
  logic [5:0] image_q, image_d;
  logic [7:0] orow_q, orow_d;
  logic [7:0] ocol_q, ocol_d;

  // per-element working registers
  logic [5:0]      w_image_q;
  logic [7:0]      w_chan_q;
  logic [7:0]      w_row_q;
  logic [7:0]      w_col_q;
  logic            w_pad_q;
  logic            w_last_q;
  logic            w_hit_q;
  logic [P1_W-1:0] p1_q;
  logic [P2_W-1:0] p2_q;
  logic [P3_W-1:0] p3_q;
  logic [31:0]     rd_q;

  logic            out_valid_q;
  out_item_t       out_q;

  logic ocol_wrap, orow_wrap, image_wrap, kcol_wrap, krow_wrap, chan_wrap;
  logic last_now, pad_now, start_emit, out_free, src_ok;
  logic [ROW_CALC_W-1:0] row_sum, row_rel;
  logic [COL_CALC_W-1:0] col_sum, col_rel;

  assign q_pop_o    = (state_q == ST_IDLE) && q_valid_i;
  assign start_emit = q_pop_o && (q_cmd_i.kind == CMD_EMIT);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign src_ok     = 32'(p3_q) < 32'(STORE_DEPTH);

  // window position and padding test
  assign row_sum = ROW_CALC_W'(orow_q) * ROW_CALC_W'(STRIDE_H) + ROW_CALC_W'(krow_q);
  assign col_sum = COL_CALC_W'(ocol_q) * COL_CALC_W'(STRIDE_W) + COL_CALC_W'(kcol_q);
  assign row_rel = row_sum - ROW_CALC_W'(PAD_H);
  assign col_rel = col_sum - COL_CALC_W'(PAD_W);
  assign pad_now = (row_sum < ROW_CALC_W'(PAD_H)) ||
                   (row_rel >= ROW_CALC_W'(cfg_i.in_height)) ||
                   (col_sum < COL_CALC_W'(PAD_W)) ||
                   (col_rel >= COL_CALC_W'(cfg_i.in_width));

  // counter wrap tests
  assign ocol_wrap  = ({1'b0, ocol_q} + 9'd1) >= cfg_i.out_width;
  assign orow_wrap  = ({1'b0, orow_q} + 9'd1) >= cfg_i.out_height;
  assign image_wrap = ({1'b0, image_q} + 7'd1) >= cfg_i.batch_count;
  assign kcol_wrap  = ({1'b0, kcol_q} + 5'd1) >= cfg_i.kernel_width;
  assign krow_wrap  = ({1'b0, krow_q} + 5'd1) >= cfg_i.kernel_height;
  assign chan_wrap  = ({1'b0, chan_q} + 9'd1) >= cfg_i.channel_count;
  assign last_now   = ocol_wrap && orow_wrap && image_wrap &&
                      kcol_wrap && krow_wrap && chan_wrap;

  always_comb begin
    ocol_d  = ocol_q;
    orow_d  = orow_q;
    image_d = image_q;
    kcol_d  = kcol_q;
    krow_d  = krow_q;
    chan_d  = chan_q;
    if (start_emit) begin
      ocol_d = ocol_wrap ? '0 : ocol_q + 1'b1;
      if (ocol_wrap) begin
        orow_d = orow_wrap ? '0 : orow_q + 1'b1;
        if (orow_wrap) begin
          image_d = image_wrap ? '0 : image_q + 1'b1;
          if (image_wrap) begin
            kcol_d = kcol_wrap ? '0 : kcol_q + 1'b1;
            if (kcol_wrap) begin
              krow_d = krow_wrap ? '0 : krow_q + 1'b1;
              if (krow_wrap) begin
                chan_d = chan_wrap ? '0 : chan_q + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_emit) begin
          state_d = pad_now ? ST_OUT : ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_READ;
      ST_READ: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chan_q      <= '0;
      krow_q      <= '0;
      kcol_q      <= '0;
      image_q     <= '0;
      orow_q      <= '0;
      ocol_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
      krow_q  <= krow_d;
      kcol_q  <= kcol_d;
      image_q <= image_d;
      orow_q  <= orow_d;
      ocol_q  <= ocol_d;
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_emit) begin
      w_image_q <= image_q;
      w_chan_q  <= chan_q;
      w_row_q   <= row_rel[7:0];
      w_col_q   <= col_rel[7:0];
      w_pad_q   <= pad_now;
      w_last_q  <= last_now;
      w_hit_q   <= 1'b0;
    end
    if (state_q == ST_MUL1) begin
      p1_q <= P1_W'(w_image_q) * P1_W'(cfg_i.channel_count) + P1_W'(w_chan_q);
    end
    if (state_q == ST_MUL2) begin
      p2_q <= P2_W'(p1_q) * P2_W'(cfg_i.in_height) + P2_W'(w_row_q);
    end
    if (state_q == ST_MUL3) begin
      p3_q <= P3_W'(p2_q) * P3_W'(cfg_i.in_width) + P3_W'(w_col_q);
    end
    if (state_q == ST_READ) begin
      w_hit_q <= src_ok;
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_q.col_value    <= w_hit_q ? rd_q : '0;
      out_q.is_padding   <= w_pad_q;
      out_q.last_element <= w_last_q;
    end
  end

  // tensor store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (q_pop_o && (q_cmd_i.kind == CMD_LOAD)) begin
      mem[ADDR_W'(q_cmd_i.index)] <= q_cmd_i.value;
    end
    if (state_q == ST_READ) begin
      rd_q <= mem[p3_q[ADDR_W-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("back state not one-hot");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output step");
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_padding |-> out_q.col_value == '0)
    else $error("padded element carries data");
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_emit && last_now |=> (chan_q == '0) && (krow_q == '0) && (kcol_q == '0) &&
      (image_q == '0) && (orow_q == '0) && (ocol_q == '0))
    else $error("counters did not wrap after last element");
`endif

endmodule

`default_nettype wire

>>> src/im2col_unfold_top.sv
// ----------------------------------------------------------------------------
// im2col_unfold_top
// im2col unfold engine: loads a tensor into an on-chip store and streams
// out the column matrix one element per emit request
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                    payload
//   in        sink       in_valid_i / in_stall_o      in_i  (op, index, value)
//   out       source     out_valid_o / out_stall_i    out_o (value, pad, last)
//   cfg       sink       cfg_we_i                     cfg_idx_i, cfg_data_i
//
// back end: a load is written on pop, a padded emit goes to the output
// register, an emit reading the store takes three multiply-add steps for
// the flat source index, one registered store read, then the output register
// the front pushes into a 2-deep request queue, so until it fills requests
// keep arriving while the back end works or a result waits on out_stall_i
// reset clears the sweep counters, queue and output valid and sets every
// register to 1; store contents are undefined until loaded
//
`default_nettype none

module im2col_unfold_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire im2col_pkg::in_item_t  in_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output im2col_pkg::out_item_t      out_o,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire im2col_pkg::cfg_reg_e  cfg_idx_i,
  input  wire logic [8:0]            cfg_data_i
);
  import im2col_pkg::*;

  cfg_t cfg_q;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // clamp a masked register value into 1..high
  function automatic logic [8:0] clamp_reg(logic [8:0] v, logic [8:0] hi);
    logic [8:0] r;
    if (v == '0) begin
      r = 9'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // registers hold effective values, clamped at write time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.batch_count   <= 7'd1;
      cfg_q.channel_count <= 9'd1;
      cfg_q.in_height     <= 9'd1;
      cfg_q.in_width      <= 9'd1;
      cfg_q.kernel_height <= 5'd1;
      cfg_q.kernel_width  <= 5'd1;
      cfg_q.out_height    <= 9'd1;
      cfg_q.out_width     <= 9'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BATCH_COUNT: begin
          cfg_q.batch_count <= 7'(clamp_reg({2'b0, cfg_data_i[6:0]}, 9'(BATCH_HIGH)));
        end
        REG_CHANNEL_COUNT: cfg_q.channel_count <= clamp_reg(cfg_data_i, DIM_HIGH);
        REG_IN_HEIGHT:     cfg_q.in_height     <= clamp_reg(cfg_data_i, DIM_HIGH);
        REG_IN_WIDTH:      cfg_q.in_width      <= clamp_reg(cfg_data_i, DIM_HIGH);
        REG_KERNEL_HEIGHT: begin
          cfg_q.kernel_height <= 5'(clamp_reg({4'b0, cfg_data_i[4:0]}, 9'(KERNEL_HIGH)));
        end
        REG_KERNEL_WIDTH: begin
          cfg_q.kernel_width <= 5'(clamp_reg({4'b0, cfg_data_i[4:0]}, 9'(KERNEL_HIGH)));
        end
        REG_OUT_HEIGHT:    cfg_q.out_height    <= clamp_reg(cfg_data_i, DIM_HIGH);
        REG_OUT_WIDTH:     cfg_q.out_width     <= clamp_reg(cfg_data_i, DIM_HIGH);
        default: ;
      endcase
    end
  end

  // front: accept and classify requests
  im2col_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .q_full_i   (q_full)
  );

  // decoupling queue
  im2col_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  // back: store, sweep counters, index arithmetic, output register
  im2col_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

`ifndef NO_ASSERTIONS
  a_cfg_batch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.batch_count != '0) && (cfg_q.batch_count <= BATCH_HIGH))
    else $error("batch count out of range");
  a_cfg_kernel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.kernel_height != '0) && (cfg_q.kernel_width != '0) &&
    (cfg_q.kernel_height <= KERNEL_HIGH) && (cfg_q.kernel_width <= KERNEL_HIGH))
    else $error("kernel size out of range");
  a_cfg_dim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.in_height != '0) && (cfg_q.in_width != '0) && (cfg_q.channel_count != '0) &&
    (cfg_q.out_height != '0) && (cfg_q.out_width != '0))
    else $error("dimension register zero");
`endif

endmodule

`default_nettype wire
